FILE: hw/rtl/dops_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense object pixel selector package
// Shared widths, register map, reset values and the raster position struct.
// ----------------------------------------------------------------------------
package dops_pkg;

  // Field widths
  localparam int unsigned DataW  = 16;
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned StepW  = 5;
  localparam int unsigned PhaseW = 4;

  // Largest sampling stride and the number of grid phase counters it needs
  localparam int unsigned StepMax = 16;

  // APB register map (byte addressed, one register per word)
  localparam int unsigned AddrW = 4;
  localparam int unsigned PDataW = 32;

  typedef enum logic [1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegMaxDepth    = 2'd2,
    RegSampleStep  = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [DimW-1:0]  FrameWidthRst  = 13'd640;
  localparam logic [DimW-1:0]  FrameHeightRst = 13'd480;
  localparam logic [DataW-1:0] MaxDepthRst    = 16'd40000;
  localparam logic [StepW-1:0] SampleStepRst  = 5'd4;

  // Raster position of the pixel held in the input stage
  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              on_grid;
  } pos_t;

endpackage

FILE: hw/rtl/dops_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel with label, depth and optical flow.
// ----------------------------------------------------------------------------
interface dops_pix_if import dops_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic        [DataW-1:0] object_label;
  logic        [DataW-1:0] pixel_depth;
  logic signed [DataW-1:0] flow_x;
  logic signed [DataW-1:0] flow_y;

  modport source (output valid, object_label, pixel_depth, flow_x, flow_y, input ready);
  modport sink   (input valid, object_label, pixel_depth, flow_x, flow_y, output ready);

endinterface

FILE: hw/rtl/dops_sel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selected pixel channel
// Valid/ready channel carrying one selected pixel and its matched position.
// ----------------------------------------------------------------------------
interface dops_sel_if import dops_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic        [CoordW-1:0] pixel_col;
  logic        [CoordW-1:0] pixel_row;
  logic        [DataW-1:0]  match_col;
  logic        [DataW-1:0]  match_row;
  logic signed [DataW-1:0]  flow_x_out;
  logic signed [DataW-1:0]  flow_y_out;
  logic        [DataW-1:0]  depth_out;
  logic        [DataW-1:0]  label_out;

  modport source (output valid, pixel_col, pixel_row, match_col, match_row,
                  flow_x_out, flow_y_out, depth_out, label_out, input ready);
  modport sink   (input valid, pixel_col, pixel_row, match_col, match_row,
                  flow_x_out, flow_y_out, depth_out, label_out, output ready);

endinterface

FILE: hw/rtl/dops_raster_cnt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster counter
// Column and row counters that wrap at the frame size, plus one phase counter
// per possible stride so that the sampling grid test needs no divider.
// ----------------------------------------------------------------------------
module dops_raster_cnt import dops_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [DimW-1:0]   width_i,
  input  logic [DimW-1:0]   height_i,
  input  logic [PhaseW-1:0] step_idx_i,
  output pos_t              pos_o
);

  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [PhaseW-1:0] col_ph_q [StepMax];
  logic [PhaseW-1:0] col_ph_d [StepMax];
  logic [PhaseW-1:0] row_ph_q [StepMax];
  logic [PhaseW-1:0] row_ph_d [StepMax];
  logic [DimW-1:0]   col_inc;
  logic [DimW-1:0]   row_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic [StepMax-1:0] col_zero;
  logic [StepMax-1:0] row_zero;

  // Next position; a counter at or past the size wraps at the next advance.
  always_comb begin
    col_inc  = {1'b0, col_q} + 13'd1;
    row_inc  = {1'b0, row_q} + 13'd1;
    col_wrap = col_inc >= width_i;
    row_wrap = row_inc >= height_i;
    col_d    = col_q;
    row_d    = row_q;
    col_ph_d = col_ph_q;
    row_ph_d = row_ph_q;
    if (advance_i) begin
      if (col_wrap) begin
        col_d = '0;
        for (int i = 0; i < StepMax; i++) begin
          col_ph_d[i] = '0;
        end
        if (row_wrap) begin
          row_d = '0;
          for (int i = 0; i < StepMax; i++) begin
            row_ph_d[i] = '0;
          end
        end else begin
          row_d = row_inc[CoordW-1:0];
          // Phase i counts the row modulo i+1
          for (int i = 0; i < StepMax; i++) begin
            row_ph_d[i] = (row_ph_q[i] == PhaseW'(i)) ? '0 : row_ph_q[i] + 4'd1;
          end
        end
      end else begin
        col_d = col_inc[CoordW-1:0];
        for (int i = 0; i < StepMax; i++) begin
          col_ph_d[i] = (col_ph_q[i] == PhaseW'(i)) ? '0 : col_ph_q[i] + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < StepMax; i++) begin
        col_ph_q[i] <= '0;
        row_ph_q[i] <= '0;
      end
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      col_ph_q <= col_ph_d;
      row_ph_q <= row_ph_d;
    end
  end

  // Grid hit: both coordinates are multiples of the selected stride.
  always_comb begin
    for (int i = 0; i < StepMax; i++) begin
      col_zero[i] = col_ph_q[i] == '0;
      row_zero[i] = row_ph_q[i] == '0;
    end
    pos_o.col     = col_q;
    pos_o.row     = row_q;
    pos_o.on_grid = col_zero[step_idx_i] & row_zero[step_idx_i];
  end

endmodule

FILE: hw/rtl/dense_object_pixel_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense object pixel selector
// Samples a labeled depth and flow image on a grid and passes on the pixels
// of valid objects whose flow-displaced position stays inside the frame.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Contents
//   pix_i     in         valid/ready           label, depth, flow_x, flow_y
//   sel_o     out        valid/ready           position, match, flow, depth, label
//   APB       in         psel/penable/pready   frame size, depth limit, stride
//
// One pixel is accepted every cycle unless the input stage stalls; a result passes
// through the input register, then the result register.
// The two stages stall only when the result register is full and not taken;
// pixels that are not selected drain from the input stage regardless.
// Reset restores the register defaults and returns the raster to row 0, col 0.
// ----------------------------------------------------------------------------
module dense_object_pixel_selector import dops_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dops_pix_if.sink           pix_i,
  dops_sel_if.source         sel_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [PDataW-1:0]  pwdata,
  output logic [PDataW-1:0]  prdata,
  output logic               pready
);

  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  // Configuration registers
  logic [DimW-1:0]  frame_width_q;
  logic [DimW-1:0]  frame_height_q;
  logic [DataW-1:0] max_depth_q;
  logic [StepW-1:0] sample_step_q;
  cfg_reg_e         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      max_depth_q    <= MaxDepthRst;
      sample_step_q  <= SampleStepRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegFrameWidth:  frame_width_q  <= pwdata[DimW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[DimW-1:0];
        RegMaxDepth:    max_depth_q    <= pwdata[DataW-1:0];
        RegSampleStep:  sample_step_q  <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_sel)
      RegFrameWidth:  prdata = PDataW'(frame_width_q);
      RegFrameHeight: prdata = PDataW'(frame_height_q);
      RegMaxDepth:    prdata = PDataW'(max_depth_q);
      RegSampleStep:  prdata = PDataW'(sample_step_q);
      default:        prdata = '0;
    endcase
  end

  // Effective frame size and stride after clamping.
  logic [DimW-1:0]   width_eff;
  logic [DimW-1:0]   height_eff;
  logic [PhaseW-1:0] step_idx;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = 13'd1;
    end else if (frame_width_q > MaxDim) begin
      width_eff = MaxDim;
    end else begin
      width_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      height_eff = 13'd1;
    end else if (frame_height_q > MaxDim) begin
      height_eff = MaxDim;
    end else begin
      height_eff = frame_height_q;
    end
    if (sample_step_q == '0) begin
      step_idx = '0;
    end else if (sample_step_q > StepW'(StepMax)) begin
      step_idx = PhaseW'(StepMax - 1);
    end else begin
      step_idx = PhaseW'(sample_step_q - 5'd1);
    end
  end

  // Handshake control
  logic pix_acc;
  logic s1_valid_q;
  logic s1_hit;
  logic s1_drain;
  logic out_free;
  logic sel_valid_q;

  assign out_free    = ~sel_valid_q | sel_o.ready;
  assign s1_drain    = out_free | ~s1_hit;
  assign pix_i.ready = ~s1_valid_q | s1_drain;
  assign pix_acc     = pix_i.valid & pix_i.ready;

  // Raster position of the next accepted pixel
  pos_t pos;

  dops_raster_cnt u_raster_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (pix_acc),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .step_idx_i (step_idx),
    .pos_o      (pos)
  );

  // Input stage: pixel payload and its position
  logic        [DataW-1:0] s1_label_q;
  logic        [DataW-1:0] s1_depth_q;
  logic signed [DataW-1:0] s1_fx_q;
  logic signed [DataW-1:0] s1_fy_q;
  pos_t                    s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_label_q <= pix_i.object_label;
      s1_depth_q <= pix_i.pixel_depth;
      s1_fx_q    <= pix_i.flow_x;
      s1_fy_q    <= pix_i.flow_y;
      s1_pos_q   <= pos;
    end
  end

  // Selection: matched position in 1/16 pixel and all acceptance tests.
  logic signed [DataW+1:0] mcol;
  logic signed [DataW+1:0] mrow;
  logic signed [DataW+1:0] wlim;
  logic signed [DataW+1:0] hlim;

  always_comb begin
    mcol   = $signed({2'b00, s1_pos_q.col, 4'b0000}) + (DataW+2)'(s1_fx_q);
    mrow   = $signed({2'b00, s1_pos_q.row, 4'b0000}) + (DataW+2)'(s1_fy_q);
    wlim   = $signed({1'b0, width_eff, 4'b0000});
    hlim   = $signed({1'b0, height_eff, 4'b0000});
    s1_hit = s1_valid_q & s1_pos_q.on_grid
           & (s1_label_q != '0)
           & (s1_depth_q != '0) & (s1_depth_q < max_depth_q)
           & (mcol > 0) & (mcol < wlim)
           & (mrow > 0) & (mrow < hlim);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (out_free) begin
      sel_valid_q <= s1_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_hit) begin
      sel_o.pixel_col  <= s1_pos_q.col;
      sel_o.pixel_row  <= s1_pos_q.row;
      sel_o.match_col  <= mcol[DataW-1:0];
      sel_o.match_row  <= mrow[DataW-1:0];
      sel_o.flow_x_out <= s1_fx_q;
      sel_o.flow_y_out <= s1_fy_q;
      sel_o.depth_out  <= s1_depth_q;
      sel_o.label_out  <= s1_label_q;
    end
  end

  assign sel_o.valid = sel_valid_q;

  // A stalled input can only come from a full, untaken result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (sel_valid_q && !sel_o.ready))
    else $error("input stalled without a blocked result");

  // Every delivered result belongs to a labeled pixel with valid depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_valid_q |-> (sel_o.label_out != '0 && sel_o.depth_out != '0))
    else $error("result carries background label or invalid depth");

  // The column either steps by one or wraps to zero on each accepted pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> (pos.col == $past(pos.col) + 12'd1) || (pos.col == '0))
    else $error("column counter skipped");

  // The row only moves when the column wraps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos.row != $past(pos.row)) |-> (pos.col == '0))
    else $error("row counter moved mid-row");

endmodule

FILE: dv/pixel_selection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel selection checker
// Follows the register writes and the pixel stream, predicts which pixels are
// selected and compares every selected pixel against that prediction.
// ----------------------------------------------------------------------------
module pixel_selection_checker import dops_pkg::*; #(
  parameter int unsigned MaxDim = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dops_pix_if               pix_i,
  dops_sel_if               sel_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [DataW-1:0]  match_col;
    logic [DataW-1:0]  match_row;
    logic [DataW-1:0]  flow_x;
    logic [DataW-1:0]  flow_y;
    logic [DataW-1:0]  depth;
    logic [DataW-1:0]  label;
  } sel_item_t;

  // Selected pixels predicted but not yet seen on the output, oldest first.
  sel_item_t expected_sel_q[$];

  // Shadow copy of the registers and of the raster position.
  logic [DimW-1:0]   frame_width_q;
  logic [DimW-1:0]   frame_height_q;
  logic [DataW-1:0]  max_depth_q;
  logic [StepW-1:0]  step_q;
  logic [CoordW-1:0] col_q;
  logic [CoordW-1:0] row_q;

  // A frame size of zero behaves as one, and sizes above the maximum saturate.
  function automatic int unsigned clamp_dim(input logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors_o++;
  endtask

  // Decide whether the pixel request just accepted is selected, then step
  // the raster position the same way the block does.
  task automatic predict_selection();
    int unsigned w;
    int unsigned h;
    int unsigned step_eff;
    int unsigned next_col;
    int unsigned next_row;
    int          mcol;
    int          mrow;
    sel_item_t   item;
    w = clamp_dim(frame_width_q);
    h = clamp_dim(frame_height_q);
    step_eff = (step_q == '0) ? 1 : ((step_q > StepMax) ? StepMax : step_q);
    mcol = int'(col_q) * 16 + int'(pix_i.flow_x);
    mrow = int'(row_q) * 16 + int'(pix_i.flow_y);
    if ((int'(col_q) % step_eff == 0) && (int'(row_q) % step_eff == 0) &&
        (pix_i.object_label != '0) && (pix_i.pixel_depth != '0) &&
        (pix_i.pixel_depth < max_depth_q) &&
        (mcol > 0) && (mcol < int'(w * 16)) &&
        (mrow > 0) && (mrow < int'(h * 16))) begin
      item.col       = col_q;
      item.row       = row_q;
      item.match_col = mcol[DataW-1:0];
      item.match_row = mrow[DataW-1:0];
      item.flow_x    = pix_i.flow_x;
      item.flow_y    = pix_i.flow_y;
      item.depth     = pix_i.pixel_depth;
      item.label     = pix_i.object_label;
      expected_sel_q.insert(expected_sel_q.size(), item);
    end
    // A counter at or past a shrunken size wraps at its next advance.
    next_col = int'(col_q) + 1;
    next_row = int'(row_q);
    if (next_col >= w) begin
      next_col = 0;
      next_row = next_row + 1;
      if (next_row >= h) next_row = 0;
    end
    col_q = next_col[CoordW-1:0];
    row_q = next_row[CoordW-1:0];
  endtask

  // Compare one selected pixel with the oldest prediction.
  task automatic check_selection();
    sel_item_t want;
    if (expected_sel_q.size() == 0) begin
      report_mismatch("selected pixel with none expected (row, col)",
                      {4'h0, sel_i.pixel_row, 4'h0, sel_i.pixel_col}, '0);
      return;
    end
    want = expected_sel_q.pop_front();
    if (sel_i.pixel_col !== want.col)
      report_mismatch("pixel_col", sel_i.pixel_col, want.col);
    if (sel_i.pixel_row !== want.row)
      report_mismatch("pixel_row", sel_i.pixel_row, want.row);
    if (sel_i.match_col !== want.match_col)
      report_mismatch("match_col", sel_i.match_col, want.match_col);
    if (sel_i.match_row !== want.match_row)
      report_mismatch("match_row", sel_i.match_row, want.match_row);
    if (sel_i.flow_x_out !== want.flow_x)
      report_mismatch("flow_x_out", sel_i.flow_x_out, want.flow_x);
    if (sel_i.flow_y_out !== want.flow_y)
      report_mismatch("flow_y_out", sel_i.flow_y_out, want.flow_y);
    if (sel_i.depth_out !== want.depth)
      report_mismatch("depth_out", sel_i.depth_out, want.depth);
    if (sel_i.label_out !== want.label)
      report_mismatch("label_out", sel_i.label_out, want.label);
  endtask

  // Results are checked before new pixels are predicted, since a pixel
  // accepted at this edge cannot be the one leaving at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  = FrameWidthRst;
      frame_height_q = FrameHeightRst;
      max_depth_q    = MaxDepthRst;
      step_q         = SampleStepRst;
      col_q          = '0;
      row_q          = '0;
      expected_sel_q.delete();
      errors_o       = 0;
      pending_o      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[AddrW-1:2]))
          RegFrameWidth:  frame_width_q  = pwdata[DimW-1:0];
          RegFrameHeight: frame_height_q = pwdata[DimW-1:0];
          RegMaxDepth:    max_depth_q    = pwdata[DataW-1:0];
          RegSampleStep:  step_q         = pwdata[StepW-1:0];
          default: ;
        endcase
      end
      if (sel_i.valid && sel_i.ready) check_selection();
      if (pix_i.valid && pix_i.ready) predict_selection();
      pending_o = expected_sel_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense object pixel selector testbench
// Drives pixel requests and register writes into the selector, with random
// gaps and stalls on both channels, and leaves prediction and comparison to
// the pixel selection checker.
// ----------------------------------------------------------------------------
module tb_top;
  import dops_pkg::*;

  localparam int unsigned MaxDim       = 4096;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned RandomPixels = 1250;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned CycleLimit   = 200000;

  typedef struct packed {
    logic [DataW-1:0] label;
    logic [DataW-1:0] depth;
    logic [DataW-1:0] flow_x;
    logic [DataW-1:0] flow_y;
  } pixel_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int unsigned       mismatch_count;
  int unsigned       pending_count;
  int unsigned       cycle_count = 0;
  bit                no_idle     = 1'b0;
  bit                hold_output = 1'b0;
  logic [DataW-1:0]  depth_limit = MaxDepthRst;

  dops_pix_if pix_if ();
  dops_sel_if sel_if ();

  dense_object_pixel_selector #(
    .MAX_DIM (MaxDim)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_i   (pix_if),
    .sel_o   (sel_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pixel_selection_checker #(
    .MaxDim (MaxDim)
  ) u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .pix_i     (pix_if),
    .sel_i     (sel_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors_o  (mismatch_count),
    .pending_o (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stalls, a quiet stretch, and one long hold-off that
  // lets the block fill up while pixel requests keep coming.
  initial begin
    sel_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        sel_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else begin
        sel_if.ready <= no_idle || ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    logic [PDataW-1:0] keep;
    case (idx)
      RegFrameWidth, RegFrameHeight: keep = (1 << DimW) - 1;
      RegMaxDepth:                   keep = (1 << DataW) - 1;
      default:                       keep = (1 << StepW) - 1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= ($urandom() & ~keep) | (value & keep);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned width, input int unsigned height,
                           input int unsigned max_depth, input int unsigned step);
    write_reg(RegFrameWidth, width);
    write_reg(RegFrameHeight, height);
    write_reg(RegMaxDepth, max_depth);
    write_reg(RegSampleStep, step);
    depth_limit = max_depth[DataW-1:0];
  endtask

  // Offer one pixel request and hold it until the block takes it.
  task automatic send_pixel(input pixel_t p);
    if (!no_idle) begin
      while ($urandom_range(99) < 12) begin
        pix_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    pix_if.valid        <= 1'b1;
    pix_if.object_label <= p.label;
    pix_if.pixel_depth  <= p.depth;
    pix_if.flow_x       <= p.flow_x;
    pix_if.flow_y       <= p.flow_y;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering pixels until every selected pixel is out, then give the
  // pipeline time to flush pixels that select nothing.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Small flows keep most displaced positions inside the frame.
  function automatic logic [DataW-1:0] random_flow();
    int unsigned f;
    f = $urandom_range(99);
    if (f < 85) return DataW'($urandom_range(96)) - 16'd48;
    if (f < 93) return DataW'($urandom());
    case ($urandom_range(3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly object pixels with a usable depth; the rest are background,
  // invalid or too deep.
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)       p.label = '0;
    else if (r < 14) p.label = 16'hFFFF;
    else             p.label = DataW'($urandom_range(65535, 1));
    r = $urandom_range(99);
    if (r < 6)                 p.depth = '0;
    else if (r < 12)           p.depth = 16'hFFFF;
    else if (r < 20)           p.depth = DataW'($urandom());
    else if (depth_limit > 1)  p.depth = DataW'($urandom_range(depth_limit - 1, 1));
    else                       p.depth = DataW'($urandom_range(65535, 1));
    p.flow_x = random_flow();
    p.flow_y = random_flow();
    return p;
  endfunction

  // Mostly small frames so that rows wrap often; sometimes zero or oversize.
  function automatic int unsigned random_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(24, 1);
    if (r < 78) return 0;
    if (r < 86) return $urandom_range(8191, 4096);
    return $urandom_range(8191, 0);
  endfunction

  function automatic int unsigned random_step();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(4, 1);
    if (r < 65) return 0;
    if (r < 85) return $urandom_range(16, 5);
    return $urandom_range(31, 17);
  endfunction

  function automatic int unsigned random_max_depth();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(65535, 1);
    if (r < 65) return 16'hFFFF;
    if (r < 72) return 0;
    return $urandom_range(400, 1);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_if.valid        = 1'b0;
    pix_if.object_label = '0;
    pix_if.pixel_depth  = '0;
    pix_if.flow_x       = '0;
    pix_if.flow_y       = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A 4x4 frame, every pixel on the grid: edges of the displaced position,
    // the depth bounds, background labels and extreme flows.
    configure(4, 4, 1000, 1);
    send_pixel('{16'd1,    16'd1,    16'd1,    16'd1});
    send_pixel('{16'd0,    16'd500,  16'd16,   16'd16});
    send_pixel('{16'hFFFF, 16'd999,  16'd0,    16'd0});
    send_pixel('{16'd5,    16'd500,  16'd15,   16'd1});
    send_pixel('{16'd7,    16'd1000, 16'd8,    16'd8});
    send_pixel('{16'd7,    16'd0,    16'd8,    16'd8});
    send_pixel('{16'hFFFF, 16'd999,  16'h7FFF, 16'd8});
    send_pixel('{16'd9,    16'd999,  16'h8000, 16'd8});
    send_pixel('{16'd9,    16'd999,  16'd0,    16'd0});
    send_pixel('{16'd9,    16'd999,  16'hFFF1, 16'd31});
    send_pixel('{16'd9,    16'd999,  16'd0,    16'd32});
    send_pixel('{16'd9,    16'd999,  16'd0,    16'hFFE0});
    send_pixel('{16'd3,    16'd300,  16'd16,   16'hFFD1});
    send_pixel('{16'd3,    16'hFFFF, 16'd1,    16'd1});
    send_pixel('{16'd3,    16'd300,  16'd1,    16'h7FFF});
    send_pixel('{16'd3,    16'd300,  16'd1,    16'h8000});
    wait_drained();

    // Zero frame size and zero step act as one; a zero threshold blocks all.
    configure(0, 0, 0, 0);
    send_pixel('{16'd1,    16'd1,    16'd8,    16'd8});
    send_pixel('{16'hFFFF, 16'hFFFE, 16'd1,    16'd1});
    wait_drained();
    configure(0, 0, 16'hFFFF, 0);
    send_pixel('{16'hFFFF, 16'hFFFE, 16'd15,   16'd15});
    send_pixel('{16'd1,    16'd1,    16'd16,   16'd8});
    wait_drained();

    // Oversize frame and step saturate.
    configure(8191, 8191, 16'hFFFF, 31);
    send_pixel('{16'd2,    16'd2,    16'd1,    16'd1});
    send_pixel('{16'd2,    16'd2,    16'd1,    16'd1});
    send_pixel('{16'd2,    16'd2,    16'd1,    16'd1});

    // Random phases, each started from an empty block with new settings.
    sent  = 0;
    phase = 0;
    while (sent < RandomPixels) begin
      wait_drained();
      if (phase == 1) begin
        configure(16, 16, 16'hFFFF, 1);
        hold_output = 1'b1;
      end else begin
        configure(random_dim(), random_dim(), random_max_depth(), random_step());
      end
      no_idle = (phase == 3) || (phase == 4);
      n = $urandom_range(150, 30);
      repeat (n) begin
        send_pixel(random_pixel());
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;
    wait_drained();

    if (pending_count != 0)
      $display("tb_top: %0d selected pixels never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dops_pkg.sv
hw/rtl/dops_pix_if.sv
hw/rtl/dops_sel_if.sv
hw/rtl/dops_raster_cnt.sv
hw/rtl/dense_object_pixel_selector.sv
dv/pixel_selection_checker.sv
dv/tb_top.sv
